### rtl/core/chbs_pkg.sv
// shared types and constants for the counter-hash bernoulli subsampler
package chbs_pkg;

  localparam int ID_W     = 64;
  localparam int WORD_W   = 64;
  localparam int THR_W    = 54;
  localparam int SEED_W   = 32;
  localparam int FRAC_LSB = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;
  localparam int NUM_KS     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED           = 1'b1;

  localparam logic [WORD_W-1:0] TF_PARITY = 64'h1BD1_1BDA_A9FC_1A22;

  localparam int unsigned ROT_TBL [8] = '{16, 42, 12, 31, 16, 32, 24, 21};

  typedef logic [NUM_KS-1:0][WORD_W-1:0] ks_t;

  typedef struct packed {
    logic [WORD_W-1:0] x0;
    logic [WORD_W-1:0] x1;
    logic [ID_W-1:0]   id;
    logic              last;
  } stage_t;

endpackage

### rtl/core/chbs_if.sv
// item channel interfaces for the subsampler input and result streams
interface chbs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] particle_id;
  logic        last_item;

  modport source (output valid, output particle_id, output last_item, input ready);
  modport sink   (input valid, input particle_id, input last_item, output ready);
endinterface

interface chbs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] particle_id_out;
  logic        keep;
  logic        last_out;

  modport source (output valid, output particle_id_out, output keep, output last_out,
                  input ready);
  modport sink   (input valid, input particle_id_out, input keep, input last_out,
                  output ready);
endinterface

### rtl/core/chbs_round.sv
// one registered threefry-2x64 round with optional key injection
module chbs_round
  import chbs_pkg::*;
#(
  parameter int RIDX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   vld_i,
  input  stage_t st_i,
  input  ks_t    ks_i,
  output logic   vld_o,
  output stage_t st_o
);

  localparam int  ROT    = ROT_TBL[RIDX % 8];
  localparam bit  DO_INJ = ((RIDX % 4) == 3);
  localparam int  INJ    = (RIDX + 1) / 4;
  localparam int  KA     = INJ % NUM_KS;
  localparam int  KB     = (INJ + 1) % NUM_KS;

  logic [WORD_W-1:0] x0_sum;
  logic [WORD_W-1:0] x1_rot;
  logic [WORD_W-1:0] x1_mix;
  stage_t            st_nxt;
  logic              vld_r;
  stage_t            st_r;

  always_comb begin
    x0_sum = st_i.x0 + st_i.x1;
    x1_rot = (st_i.x1 << ROT) | (st_i.x1 >> (WORD_W - ROT));
    x1_mix = x1_rot ^ x0_sum;
    st_nxt = st_i;
    if (DO_INJ) begin
      st_nxt.x0 = x0_sum + ks_i[KA];
      st_nxt.x1 = x1_mix + ks_i[KB] + WORD_W'(INJ);
    end else begin
      st_nxt.x0 = x0_sum;
      st_nxt.x1 = x1_mix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;

endmodule

### rtl/core/chbs_cipher.sv
// pipelined threefry-2x64 cipher, one round per stage
module chbs_cipher
  import chbs_pkg::*;
#(
  parameter int ROUNDS = 20
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   vld_i,
  input  stage_t st_i,
  input  ks_t    ks_i,
  output logic   vld_o,
  output stage_t st_o
);

  logic   vld_w [ROUNDS+1];
  stage_t st_w  [ROUNDS+1];

  assign vld_w[0] = vld_i;
  assign st_w[0]  = st_i;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    chbs_round #(
      .RIDX (r)
    ) u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld_w[r]),
      .st_i  (st_w[r]),
      .ks_i  (ks_i),
      .vld_o (vld_w[r+1]),
      .st_o  (st_w[r+1])
    );
  end

  assign vld_o = vld_w[ROUNDS];
  assign st_o  = st_w[ROUNDS];

endmodule

### rtl/core/counter_hash_bernoulli_subsampler.sv
// top level of the counter-hash bernoulli subsampler
//
// in_ch carries one particle item (identifier and last marker) per valid/ready
// handshake; out_ch returns exactly one item per input, in order, with the
// identifier, the keep decision and the copied last marker.
// the cfg port writes keep_threshold (index 0, unsigned 1.53 fixed point,
// 2^53 keeps all) and seed (index 1); write only while no item is in flight.
// the path holds one register per cipher round, then the
// threshold compare into the output register.
// throughput is one item per cycle unless out_ch stalls; the rounds set it.
// the whole pipeline advances together: when out_ch holds an item that is
// not taken, every stage freezes and in_ch.ready drops, nothing is lost.
// a synchronous reset empties the pipeline and clears both registers to 0,
// so after reset no particle is kept until a threshold is written.
module counter_hash_bernoulli_subsampler
  import chbs_pkg::*;
#(
  parameter int ROUNDS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  chbs_in_if.sink               in_ch,
  chbs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [THR_W-1:0]  thr_r;
  logic [SEED_W-1:0] seed_r;
  logic [WORD_W-1:0] key1;
  ks_t               ks;
  logic              adv;
  stage_t            st_in;
  logic              c_vld;
  stage_t            c_st;
  logic              keep_nxt;
  logic              out_valid_r;
  logic [ID_W-1:0]   id_r;
  logic              keep_r;
  logic              last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      seed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KEEP_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_SEED:           seed_r <= cfg_wdata[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // key schedule: key0 is zero, key1 the sign-extended seed
  assign key1  = {{(WORD_W-SEED_W){seed_r[SEED_W-1]}}, seed_r};
  assign ks[0] = '0;
  assign ks[1] = key1;
  assign ks[2] = TF_PARITY ^ key1;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // initial key add folded in: x0 = id + 0, x1 = 0 + key1
  always_comb begin
    st_in.x0   = in_ch.particle_id;
    st_in.x1   = key1;
    st_in.id   = in_ch.particle_id;
    st_in.last = in_ch.last_item;
  end

  chbs_cipher #(
    .ROUNDS (ROUNDS)
  ) u_cipher (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (in_ch.valid),
    .st_i  (st_in),
    .ks_i  (ks),
    .vld_o (c_vld),
    .st_o  (c_st)
  );

  assign keep_nxt = {1'b0, c_st.x0[WORD_W-1:FRAC_LSB]} < thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id_r   <= c_st.id;
      keep_r <= keep_nxt;
      last_r <= c_st.last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.particle_id_out = id_r;
  assign out_ch.keep            = keep_r;
  assign out_ch.last_out        = last_r;

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(c_vld))
    else $error("cipher pipeline moved during a stall");

  a_cipher_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && c_vld |=> out_valid_r)
    else $error("item from cipher pipeline lost at output register");

  a_zero_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (thr_r == '0) |-> !keep_r)
    else $error("item kept under zero threshold");

  a_full_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && thr_r[THR_W-1] && $stable(thr_r) |-> keep_r)
    else $error("item dropped under keep-all threshold");

endmodule
